>>> sv/target_arm_round_robin_defines.svh
// ---------------------------------------------------------------------------
// target arm round robin assertion macros
// shared property forms for the port-level checker
// ---------------------------------------------------------------------------
`ifndef TARGET_ARM_ROUND_ROBIN_DEFINES_SVH
`define TARGET_ARM_ROUND_ROBIN_DEFINES_SVH

// same-cycle implication
`define TRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/trr_pkg.sv
// ---------------------------------------------------------------------------
// trr_pkg
// shared types, widths, field positions and reset values of the arming block
// ---------------------------------------------------------------------------
package trr_pkg;

    localparam int MAX_NODES_DEF = 8;

    localparam int ADDR_W  = 48;
    localparam int SEQ_W   = 16;
    localparam int TIME_W  = 64;
    localparam int SESS_W  = 32;
    localparam int POS_W   = 3;
    localparam int CFG_W   = 32;
    localparam int CFG_A_W = 2;
    localparam int REQ_W   = 2;
    localparam int KIND_W  = 3;

    // input tdata layout
    localparam int IN_ADDR_LSB = 0;
    localparam int IN_SEQ_LSB  = IN_ADDR_LSB + ADDR_W;
    localparam int IN_HIT_LSB  = IN_SEQ_LSB + SEQ_W;
    localparam int IN_NOW_LSB  = IN_HIT_LSB + TIME_W;
    localparam int IN_DATA_W   = IN_NOW_LSB + TIME_W;

    // output tdata layout
    localparam int OUT_DEST_LSB  = 0;
    localparam int OUT_SESS_LSB  = OUT_DEST_LSB + ADDR_W;
    localparam int OUT_POS_LSB   = OUT_SESS_LSB + SESS_W;
    localparam int OUT_STEP_LSB  = OUT_POS_LSB + POS_W;
    localparam int OUT_STAMP_LSB = OUT_STEP_LSB + SEQ_W;
    localparam int OUT_REACT_LSB = OUT_STAMP_LSB + TIME_W;
    localparam int OUT_USED_W    = OUT_REACT_LSB + TIME_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_HELLO = 2'd1,
        REQ_PRESS = 2'd2
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PING    = 3'd0,
        KIND_SYNC    = 3'd1,
        KIND_ARM     = 3'd2,
        KIND_HIT     = 3'd3,
        KIND_TIMEOUT = 3'd4
    } msg_kind_t;

    localparam logic [CFG_A_W-1:0] CFG_REARM_DELAY = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_ARM_TIMEOUT = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_SYNC_SETTLE = 2'd2;

    localparam logic [CFG_W-1:0] REARM_DELAY_RST = CFG_W'(1500 * 1000);
    localparam logic [CFG_W-1:0] ARM_TIMEOUT_RST = CFG_W'(15000 * 1000);
    localparam logic [CFG_W-1:0] SYNC_SETTLE_RST = CFG_W'(500 * 1000);

endpackage

>>> sv/target_arm_round_robin.sv
// ---------------------------------------------------------------------------
// target_arm_round_robin
// node table, session sync and round-robin arming of reaction targets
// ---------------------------------------------------------------------------
// one item at a time: ready only in the idle state, a result may still wait
// tick session sync walks the node table and sends a sync to every node; arm or
// report tick reads one entry; hello walks the one-port node table with a
// registered read per entry; press reads one entry for its report
// output stalls hold the state machine; results are registered; synchronous
// active-low reset clears control state, not the table
module target_arm_round_robin #(
    parameter int MAX_NODES = trr_pkg::MAX_NODES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [trr_pkg::CFG_A_W-1:0]      cfg_addr,
    input  logic [trr_pkg::CFG_W-1:0]        cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // node_addr, press_seq, hit_time_us, time_us
    input  logic [trr_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type
    input  logic [trr_pkg::REQ_W-1:0]        s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // dest_addr, session number, position, step_seq, stamp_us, reaction_us, zero pad
    output logic [trr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // msg_kind
    output logic [trr_pkg::KIND_W-1:0]       m_tuser,
    output logic                             m_tlast
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECIDE = 9'b000000010,
        ST_RD     = 9'b000000100,
        ST_CMP    = 9'b000001000,
        ST_PING   = 9'b000010000,
        ST_SSYNC  = 9'b000100000,
        ST_ASYNC  = 9'b001000000,
        ST_ARM    = 9'b010000000,
        ST_REP    = 9'b100000000
    } state_t;

    function automatic logic [trr_pkg::OUT_DATA_W-1:0] pack_out(
        input logic [trr_pkg::ADDR_W-1:0] dest,
        input logic [trr_pkg::SESS_W-1:0] sess,
        input logic [trr_pkg::POS_W-1:0]  pos,
        input logic [trr_pkg::SEQ_W-1:0]  seq,
        input logic [trr_pkg::TIME_W-1:0] stamp,
        input logic [trr_pkg::TIME_W-1:0] react
    );
        return {{trr_pkg::OUT_PAD_W{1'b0}}, react, stamp, seq, pos, sess, dest};
    endfunction

    // control state
    state_t                      state_reg, state_next;
    state_t                      ret_reg, ret_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [trr_pkg::SESS_W-1:0]  session_reg, session_next;
    logic                        synced_reg, synced_next;
    logic [IDX_W-1:0]            ci_reg, ci_next;
    logic                        awaiting_reg, awaiting_next;
    logic [trr_pkg::SEQ_W-1:0]   step_reg, step_next;
    logic [trr_pkg::TIME_W-1:0]  arm_time_reg, arm_time_next;
    logic [trr_pkg::TIME_W-1:0]  next_arm_reg, next_arm_next;
    logic [trr_pkg::TIME_W-1:0]  deadline_reg, deadline_next;
    logic [trr_pkg::CFG_W-1:0]   rearm_reg, rearm_next;
    logic [trr_pkg::CFG_W-1:0]   timeout_reg, timeout_next;
    logic [trr_pkg::CFG_W-1:0]   settle_reg, settle_next;
    logic                        m_valid_reg, m_valid_next;

    // payload
    logic [trr_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [trr_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [trr_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [trr_pkg::TIME_W-1:0]  hit_reg, hit_next;
    logic [trr_pkg::TIME_W-1:0]  now_reg, now_next;
    trr_pkg::msg_kind_t          rep_kind_reg, rep_kind_next;
    logic [IDX_W-1:0]            rep_pos_reg, rep_pos_next;
    logic [trr_pkg::SEQ_W-1:0]   rep_seq_reg, rep_seq_next;
    logic [trr_pkg::TIME_W-1:0]  rep_react_reg, rep_react_next;
    logic [trr_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [trr_pkg::KIND_W-1:0]  m_user_reg, m_user_next;
    logic                        m_last_reg, m_last_next;

    // node table
    logic [trr_pkg::ADDR_W-1:0]  node_mem [MAX_NODES];
    logic [trr_pkg::ADDR_W-1:0]  rd_data_reg;
    logic                        mem_we;

    // datapath helpers
    logic                        out_free;
    logic                        idx_last;
    logic [IDX_W-1:0]            ci_adv;
    logic [trr_pkg::TIME_W-1:0]  next_diff, dl_diff, react_diff;
    logic                        reach_next, reach_dl;
    logic [trr_pkg::TIME_W-1:0]  reaction;
    logic [trr_pkg::CFG_W-1:0]   settle_eff, timeout_eff;

    logic                        emit;
    trr_pkg::msg_kind_t          e_kind;
    logic [trr_pkg::ADDR_W-1:0]  e_dest;
    logic [trr_pkg::POS_W-1:0]   e_pos;
    logic [trr_pkg::SEQ_W-1:0]   e_seq;
    logic [trr_pkg::TIME_W-1:0]  e_stamp;
    logic [trr_pkg::TIME_W-1:0]  e_react;
    logic                        e_last;

    assign out_free = !m_valid_reg || m_tready;
    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign ci_adv   = ((CNT_W'(ci_reg) + CNT_W'(1)) == count_reg) ? '0
                                                                : ci_reg + IDX_W'(1);

    // a deadline counts as reached while the wrapped difference stays non-negative
    assign next_diff  = now_reg - next_arm_reg;
    assign dl_diff    = now_reg - deadline_reg;
    assign reach_next = !next_diff[trr_pkg::TIME_W-1];
    assign reach_dl   = !dl_diff[trr_pkg::TIME_W-1];
    assign react_diff = hit_reg - arm_time_reg;
    assign reaction   = (hit_reg > arm_time_reg) ? react_diff : '0;

    assign settle_eff  = (settle_reg == '0) ? trr_pkg::CFG_W'(1) : settle_reg;
    assign timeout_eff = (timeout_reg == '0) ? trr_pkg::CFG_W'(1) : timeout_reg;

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        session_next   = session_reg;
        synced_next    = synced_reg;
        ci_next        = ci_reg;
        awaiting_next  = awaiting_reg;
        step_next      = step_reg;
        arm_time_next  = arm_time_reg;
        next_arm_next  = next_arm_reg;
        deadline_next  = deadline_reg;
        rearm_next     = rearm_reg;
        timeout_next   = timeout_reg;
        settle_next    = settle_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        seq_next       = seq_reg;
        hit_next       = hit_reg;
        now_next       = now_reg;
        rep_kind_next  = rep_kind_reg;
        rep_pos_next   = rep_pos_reg;
        rep_seq_next   = rep_seq_reg;
        rep_react_next = rep_react_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;
        mem_we         = 1'b0;
        emit           = 1'b0;
        e_kind         = trr_pkg::KIND_PING;
        e_dest         = '0;
        e_pos          = '0;
        e_seq          = '0;
        e_stamp        = '0;
        e_react        = '0;
        e_last         = 1'b0;

        if (cfg_we) begin
            case (cfg_addr)
                trr_pkg::CFG_REARM_DELAY: rearm_next   = cfg_wdata;
                trr_pkg::CFG_ARM_TIMEOUT: timeout_next = cfg_wdata;
                trr_pkg::CFG_SYNC_SETTLE: settle_next  = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next   = s_tuser;
                    addr_next  = s_tdata[trr_pkg::IN_ADDR_LSB +: trr_pkg::ADDR_W];
                    seq_next   = s_tdata[trr_pkg::IN_SEQ_LSB +: trr_pkg::SEQ_W];
                    hit_next   = s_tdata[trr_pkg::IN_HIT_LSB +: trr_pkg::TIME_W];
                    now_next   = s_tdata[trr_pkg::IN_NOW_LSB +: trr_pkg::TIME_W];
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_IDLE;
                case (req_reg)
                    trr_pkg::REQ_TICK: begin
                        if (count_reg == '0) begin
                            state_next = ST_IDLE;
                        end else if (!synced_reg) begin
                            // once per session: sync every node, first arm waits
                            session_next  = session_reg + trr_pkg::SESS_W'(1);
                            synced_next   = 1'b1;
                            next_arm_next = now_reg + trr_pkg::TIME_W'(settle_eff);
                            idx_next      = '0;
                            ret_next      = ST_SSYNC;
                            state_next    = ST_RD;
                        end else if (!awaiting_reg && reach_next) begin
                            idx_next      = ci_reg;
                            step_next     = step_reg + trr_pkg::SEQ_W'(1);
                            arm_time_next = now_reg;
                            awaiting_next = 1'b1;
                            deadline_next = now_reg + trr_pkg::TIME_W'(timeout_eff);
                            ret_next      = ST_ASYNC;
                            state_next    = ST_RD;
                        end else if (awaiting_reg && reach_dl) begin
                            idx_next       = ci_reg;
                            rep_kind_next  = trr_pkg::KIND_TIMEOUT;
                            rep_pos_next   = ci_reg;
                            rep_seq_next   = step_reg;
                            rep_react_next = '0;
                            awaiting_next  = 1'b0;
                            ci_next        = ci_adv;
                            next_arm_next  = now_reg;
                            ret_next       = ST_REP;
                            state_next     = ST_RD;
                        end
                    end
                    trr_pkg::REQ_HELLO: begin
                        if (count_reg >= CNT_W'(MAX_NODES)) begin
                            state_next = ST_IDLE;
                        end else if (count_reg == '0) begin
                            state_next = ST_PING;
                        end else begin
                            idx_next   = '0;
                            ret_next   = ST_CMP;
                            state_next = ST_RD;
                        end
                    end
                    trr_pkg::REQ_PRESS: begin
                        if (awaiting_reg && (seq_reg == step_reg)) begin
                            idx_next       = ci_reg;
                            rep_kind_next  = trr_pkg::KIND_HIT;
                            rep_pos_next   = ci_reg;
                            rep_seq_next   = step_reg;
                            rep_react_next = reaction;
                            awaiting_next  = 1'b0;
                            ci_next        = ci_adv;
                            next_arm_next  = now_reg + trr_pkg::TIME_W'(rearm_reg);
                            ret_next       = ST_REP;
                            state_next     = ST_RD;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_RD: begin
                // table read of idx_reg lands in rd_data_reg
                state_next = ret_reg;
            end
            ST_CMP: begin
                if (rd_data_reg == addr_reg) begin
                    state_next = ST_IDLE;
                end else if (idx_last) begin
                    state_next = ST_PING;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_PING: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    emit       = 1'b1;
                    e_kind     = trr_pkg::KIND_PING;
                    e_dest     = addr_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SSYNC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = trr_pkg::KIND_SYNC;
                    e_dest  = rd_data_reg;
                    e_stamp = now_reg;
                    e_last  = idx_last;
                    if (idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_ASYNC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = trr_pkg::KIND_SYNC;
                    e_dest  = rd_data_reg;
                    e_stamp = now_reg;
                    // a one-entry node table drops the arm message
                    e_last     = (MAX_NODES < 2);
                    state_next = (MAX_NODES < 2) ? ST_IDLE : ST_ARM;
                end
            end
            ST_ARM: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = trr_pkg::KIND_ARM;
                    e_dest     = rd_data_reg;
                    e_pos      = trr_pkg::POS_W'(ci_reg);
                    e_seq      = step_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = rep_kind_reg;
                    e_dest     = rd_data_reg;
                    e_pos      = trr_pkg::POS_W'(rep_pos_reg);
                    e_seq      = rep_seq_reg;
                    e_react    = rep_react_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = pack_out(e_dest, session_reg, e_pos, e_seq, e_stamp, e_react);
            m_user_next  = e_kind;
            m_last_next  = e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            idx_reg      <= '0;
            count_reg    <= '0;
            session_reg  <= '0;
            synced_reg   <= 1'b0;
            ci_reg       <= '0;
            awaiting_reg <= 1'b0;
            step_reg     <= '0;
            arm_time_reg <= '0;
            next_arm_reg <= '0;
            deadline_reg <= '0;
            rearm_reg    <= trr_pkg::REARM_DELAY_RST;
            timeout_reg  <= trr_pkg::ARM_TIMEOUT_RST;
            settle_reg   <= trr_pkg::SYNC_SETTLE_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            session_reg  <= session_next;
            synced_reg   <= synced_next;
            ci_reg       <= ci_next;
            awaiting_reg <= awaiting_next;
            step_reg     <= step_next;
            arm_time_reg <= arm_time_next;
            next_arm_reg <= next_arm_next;
            deadline_reg <= deadline_next;
            rearm_reg    <= rearm_next;
            timeout_reg  <= timeout_next;
            settle_reg   <= settle_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        seq_reg       <= seq_next;
        hit_reg       <= hit_next;
        now_reg       <= now_next;
        rep_kind_reg  <= rep_kind_next;
        rep_pos_reg   <= rep_pos_next;
        rep_seq_reg   <= rep_seq_next;
        rep_react_reg <= rep_react_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    // one write and one registered read per cycle; the write only happens in
    // the ping state and no read of that entry follows in the same item
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[count_reg[IDX_W-1:0]] <= addr_reg;
        end
        rd_data_reg <= node_mem[idx_reg];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> sv/trr_checker.sv
// ---------------------------------------------------------------------------
// trr_checker
// port-level checks of the arming block, bound to the top level
// ---------------------------------------------------------------------------
`include "target_arm_round_robin_defines.svh"

module trr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [trr_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [trr_pkg::KIND_W-1:0]       m_tuser,
    input logic                             m_tlast
);

    // a stalled result holds
    `TRR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // an item in work keeps ready low in the cycle after its transfer
    `TRR_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready right after input transfer")

    // no item is taken while a result that is not the last of its item waits
    `TRR_ASSERT_NOW(a_burst_blocks, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input taken during a result burst")

    // a ping carries only address and session
    `TRR_ASSERT_NOW(a_ping_zero, aclk, aresetn, m_tvalid && (m_tuser == trr_pkg::KIND_PING), m_tdata[trr_pkg::OUT_DATA_W-1:trr_pkg::OUT_POS_LSB] == '0, "ping with nonzero fields")

endmodule

bind target_arm_round_robin trr_checker u_trr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
